>>> rtl/core/mtcr_pkg.sv
// ----------------------------------------------------------------------------
// mtcr_pkg
// Shared types, constants and helpers for the MIDI transpose / channel
// remap unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mtcr_pkg;

  // Byte classes
  localparam logic [3:0] NIB_SYSTEM   = 4'hF;
  localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
  localparam logic [3:0] NIB_NOTE_ON  = 4'h9;

  // Configuration register indexes
  localparam logic CFG_IDX_TRANSPOSE = 1'b0;
  localparam logic CFG_IDX_CHANNEL   = 1'b1;

  localparam int CFG_DATA_W   = 8;
  localparam int CHANNEL_W    = 5;
  localparam int MAX_CHANNEL  = 16;

  // Default depth of the message queue between front and back
  localparam int MSG_FIFO_DEPTH_DEF = 2;

  // Message length codes (bytes in a rebuilt message)
  localparam logic [1:0] MSG_LEN_1 = 2'd1;
  localparam logic [1:0] MSG_LEN_2 = 2'd2;
  localparam logic [1:0] MSG_LEN_3 = 2'd3;

  // One rebuilt message, bytes sent b0 first
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] len;
  } msg_t;

  // Configuration seen by the parser
  typedef struct packed {
    logic [7:0]           transpose;
    logic [CHANNEL_W-1:0] channel;
  } cfg_t;

  // Queue status toward the serializer
  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  // Data bytes per channel status nibble
  function automatic logic [1:0] data_len(input logic [3:0] nib);
    logic [1:0] len;
    len = 2'd0;
    unique case (nib)
      4'h8, 4'h9, 4'hA, 4'hB, 4'hE: len = 2'd2;
      4'hC, 4'hD:                   len = 2'd1;
      default:                      len = 2'd0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/midi_transpose_channel_remap_unit.sv
// ----------------------------------------------------------------------------
// midi_transpose_channel_remap_unit
// MIDI running-status parser with key transpose and channel remap.
// ----------------------------------------------------------------------------
// Usage:
//   Input is a queue write port: a byte is taken on a clock edge with push
//   high and full low. Results come out as a queue read port: while empty
//   is low the oldest byte sits on out_byte / out_end_of_message, and pop
//   takes it.
//   The parser handles one byte per cycle while full is low; a completing
//   byte queues a whole message (1 to 3 bytes, status rebuilt explicitly).
//   The serializer sends one byte per cycle while the receiver pops, so the
//   output side sets the sustained rate. A completing byte's message passes
//   the message queue, then the output register. full rises when the queue
//   holds MSG_FIFO_DEPTH messages; a stalled receiver fills the queue and
//   then back-pressures the input. Configuration (cfg_we, cfg_index,
//   cfg_data) must be written while idle; the block does not enforce it.
//   Index 0 is the signed transpose, index 1 the forced channel (0 keeps).
//   Synchronous reset clears running status, queue, output and config.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_transpose_channel_remap_unit #(
  parameter int MSG_FIFO_DEPTH = mtcr_pkg::MSG_FIFO_DEPTH_DEF
) (
  input  wire  logic                          clk,
  input  wire  logic                          rst_n,
  // configuration
  input  wire  logic                          cfg_we,
  input  wire  logic                          cfg_index,
  input  wire  logic [mtcr_pkg::CFG_DATA_W-1:0] cfg_data,
  // input bytes
  input  wire  logic                          push,
  output logic                                full,
  input  wire  logic [7:0]                    in_midi_byte,
  // output bytes
  output logic                                empty,
  input  wire  logic                          pop,
  output logic [7:0]                          out_byte,
  output logic                                out_end_of_message
);

  logic [7:0]                     transpose_r;
  logic [mtcr_pkg::CHANNEL_W-1:0] channel_r;
  mtcr_pkg::cfg_t                 cfg;

  logic                 in_take;
  logic                 wr_valid;
  mtcr_pkg::msg_t       wr_msg;
  mtcr_pkg::msg_t       head_msg;
  mtcr_pkg::fifo_stat_t fifo_stat;
  logic                 head_pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      transpose_r <= '0;
      channel_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mtcr_pkg::CFG_IDX_TRANSPOSE: transpose_r <= cfg_data[7:0];
        mtcr_pkg::CFG_IDX_CHANNEL:   channel_r   <= cfg_data[mtcr_pkg::CHANNEL_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.transpose = transpose_r;
  assign cfg.channel   = channel_r;

  assign full    = fifo_stat.full;
  assign in_take = push && !fifo_stat.full;

  // Front: parse and build messages
  mtcr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .byte_valid (in_take),
    .midi_byte  (in_midi_byte),
    .msg_valid  (wr_valid),
    .msg        (wr_msg)
  );

  // Message queue
  mtcr_msg_fifo #(
    .DEPTH (MSG_FIFO_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (wr_valid),
    .wr_msg (wr_msg),
    .rd_en  (head_pop),
    .rd_msg (head_msg),
    .stat   (fifo_stat)
  );

  // Back: serialize bytes
  mtcr_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head_msg           (head_msg),
    .fifo_stat          (fifo_stat),
    .head_pop           (head_pop),
    .pop                (pop),
    .empty              (empty),
    .out_byte           (out_byte),
    .out_end_of_message (out_end_of_message)
  );

  // Output is empty right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("output not empty after reset");

  // A channel status byte only updates state, it queues nothing
  a_status_no_msg: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && in_midi_byte[7] && (in_midi_byte[7:4] != mtcr_pkg::NIB_SYSTEM))
    |-> !wr_valid)
    else $error("channel status byte produced a message");

  // Queued messages always carry at least one byte
  a_msg_len: assert property (@(posedge clk) disable iff (!rst_n)
    wr_valid |-> (wr_msg.len != 2'd0))
    else $error("queued message with zero length");

  // Within a message the next byte follows right after a pop
  a_msg_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && pop && !out_end_of_message) |=> !empty)
    else $error("gap inside an emitted message");

endmodule

`default_nettype wire

>>> rtl/core/mtcr_front.sv
// ----------------------------------------------------------------------------
// mtcr_front
// Byte parser: tracks running status, collects data bytes and builds
// complete messages with status rewrite and key transpose applied.
// ----------------------------------------------------------------------------
`default_nettype none

module mtcr_front (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire mtcr_pkg::cfg_t      cfg,
  input  wire                logic byte_valid,
  input  wire                logic [7:0] midi_byte,
  output logic                     msg_valid,
  output mtcr_pkg::msg_t           msg
);

  logic [7:0] running_status_r, running_status_nxt;
  logic       bytes_held_r, bytes_held_nxt;
  logic [7:0] first_data_r, first_data_nxt;

  logic       ch_forced;
  logic [7:0] status_out;
  logic [7:0] key_out;
  logic       is_note;

  // Status byte as sent, with optional channel override
  assign ch_forced  = (cfg.channel != '0) &&
                      (cfg.channel <= mtcr_pkg::CHANNEL_W'(mtcr_pkg::MAX_CHANNEL));
  assign status_out = ch_forced ?
                      {running_status_r[7:4], cfg.channel[3:0] - 4'd1} :
                      running_status_r;

  // Key transpose for note on / note off, wraps mod 256
  assign is_note = (running_status_r[7:4] == mtcr_pkg::NIB_NOTE_OFF) ||
                   (running_status_r[7:4] == mtcr_pkg::NIB_NOTE_ON);
  assign key_out = is_note ? (first_data_r + cfg.transpose) : first_data_r;

  // Parse one byte
  always_comb begin
    running_status_nxt = running_status_r;
    bytes_held_nxt     = bytes_held_r;
    first_data_nxt     = first_data_r;
    msg_valid          = 1'b0;
    msg                = '{b0: midi_byte, b1: midi_byte, b2: midi_byte,
                           len: mtcr_pkg::MSG_LEN_1};
    if (byte_valid) begin
      if (midi_byte[7:4] == mtcr_pkg::NIB_SYSTEM) begin
        // system byte passes alone, drops running status
        running_status_nxt = '0;
        bytes_held_nxt     = 1'b0;
        msg_valid          = 1'b1;
      end else if (midi_byte[7]) begin
        running_status_nxt = midi_byte;
        bytes_held_nxt     = 1'b0;
      end else if (running_status_r == '0) begin
        // stray data byte
        msg_valid = 1'b1;
      end else if (mtcr_pkg::data_len(running_status_r[7:4]) == 2'd1) begin
        bytes_held_nxt = 1'b0;
        msg_valid      = 1'b1;
        msg.b0         = status_out;
        msg.len        = mtcr_pkg::MSG_LEN_2;
      end else if (!bytes_held_r) begin
        first_data_nxt = midi_byte;
        bytes_held_nxt = 1'b1;
      end else begin
        bytes_held_nxt = 1'b0;
        msg_valid      = 1'b1;
        msg.b0         = status_out;
        msg.b1         = key_out;
        msg.len        = mtcr_pkg::MSG_LEN_3;
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_status_r <= '0;
      bytes_held_r     <= 1'b0;
    end else begin
      running_status_r <= running_status_nxt;
      bytes_held_r     <= bytes_held_nxt;
    end
  end

  // Held data byte, no reset needed
  always_ff @(posedge clk) begin
    first_data_r <= first_data_nxt;
  end

endmodule

`default_nettype wire

>>> rtl/core/mtcr_msg_fifo.sv
// ----------------------------------------------------------------------------
// mtcr_msg_fifo
// Short message queue between parser and serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module mtcr_msg_fifo #(
  parameter int DEPTH = mtcr_pkg::MSG_FIFO_DEPTH_DEF
) (
  input  wire             logic clk,
  input  wire             logic rst_n,
  input  wire             logic wr_en,
  input  wire mtcr_pkg::msg_t   wr_msg,
  input  wire             logic rd_en,
  output mtcr_pkg::msg_t        rd_msg,
  output mtcr_pkg::fifo_stat_t  stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mtcr_pkg::msg_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_wr, do_rd;

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign do_wr      = wr_en && !stat.full;
  assign do_rd      = rd_en && !stat.empty;
  assign rd_msg     = mem[rd_ptr_r];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr)
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_rd)
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (do_wr && !do_rd)
        count_r <= count_r + 1'b1;
      else if (do_rd && !do_wr)
        count_r <= count_r - 1'b1;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr)
      mem[wr_ptr_r] <= wr_msg;
  end

endmodule

`default_nettype wire

>>> rtl/core/mtcr_back.sv
// ----------------------------------------------------------------------------
// mtcr_back
// Serializer: sends the queued message one byte per cycle while the receiver
// pops, through an output register, marking the last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module mtcr_back (
  input  wire                 logic clk,
  input  wire                 logic rst_n,
  input  wire mtcr_pkg::msg_t       head_msg,
  input  wire mtcr_pkg::fifo_stat_t fifo_stat,
  output logic                      head_pop,
  input  wire                 logic pop,
  output logic                      empty,
  output logic [7:0]                out_byte,
  output logic                      out_end_of_message
);

  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_eom_r;
  logic       load;
  logic       last;
  logic [7:0] sel_byte;

  // Load when a message is queued and the output register is free or being drained this cycle
  assign load = !fifo_stat.empty && (!out_valid_r || pop);
  assign last = ((idx_r + 2'd1) == head_msg.len);
  assign head_pop = load && last;

  always_comb begin
    case (idx_r)
      2'd0:    sel_byte = head_msg.b0;
      2'd1:    sel_byte = head_msg.b1;
      default: sel_byte = head_msg.b2;
    endcase
  end

  always_comb begin
    idx_nxt = idx_r;
    if (load)
      idx_nxt = last ? 2'd0 : idx_r + 2'd1;
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      if (load)
        out_valid_r <= 1'b1;
      else if (pop)
        out_valid_r <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= sel_byte;
      out_eom_r  <= last;
    end
  end

  assign empty              = !out_valid_r;
  assign out_byte           = out_byte_r;
  assign out_end_of_message = out_eom_r;

endmodule

`default_nettype wire
